FILE: rtl/priority_queue_array_assert.svh
// Assertion macros shared by the priority queue RTL.
`ifndef PRIORITY_QUEUE_ARRAY_ASSERT_SVH
`define PRIORITY_QUEUE_ARRAY_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PQA_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define PQA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its trigger.
`define PQA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pqa_pkg.sv
// Shared types and constants for the priority queue.
package pqa_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam int VALUE_WIDTH    = 32;
   localparam int PRIORITY_WIDTH = 16;
   localparam int STATUS_WIDTH   = 2;

   // opcodes
   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

   // one queue entry as held in the slot memory
   typedef struct packed {
      logic [PRIORITY_WIDTH-1:0] pri;
      logic [VALUE_WIDTH-1:0]    val;
   } pqa_slot_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic scan;
      logic shift;
      logic load_rsp;
   } pqa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic deq_run;
      logic scan_last;
      logic shift_done;
   } pqa_sts_type;

endpackage

FILE: rtl/pqa_ctrl.sv
// Controller state machine of the priority queue.
`include "priority_queue_array_assert.svh"

module pqa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  pqa_pkg::pqa_sts_type sts,
   output pqa_pkg::pqa_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_SHIFT  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      cmd.accept   = req_valid && (state_ff == S_IDLE);
      cmd.scan     = (state_ff == S_SCAN);
      cmd.shift    = (state_ff == S_SHIFT);
      cmd.load_rsp = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               state_in = sts.deq_run ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            if (sts.scan_last) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (sts.shift_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (cmd.load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PQA_ASSERT_NEXT(a_accept_busy, cmd.accept, state_ff != S_IDLE, "accept left block idle")
   `PQA_ASSERT_IMPL(a_load_free, cmd.load_rsp, !(rsp_valid_ff && rsp_stall), "output overrun")
   `PQA_ASSERT_NEXT(a_load_valid, cmd.load_rsp, rsp_valid_ff, "loaded item not shown")

endmodule

FILE: rtl/pqa_dp.sv
// Datapath of the priority queue: slot memory, fill count, scan and shift.
`include "priority_queue_array_assert.svh"

module pqa_dp #(
   parameter int QUEUE_DEPTH = pqa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_opcode,
   input  logic signed [pqa_pkg::VALUE_WIDTH-1:0]    req_item_value,
   input  logic        [pqa_pkg::PRIORITY_WIDTH-1:0] req_item_priority,
   input  pqa_pkg::pqa_cmd_type                      cmd,
   output pqa_pkg::pqa_sts_type                      sts,
   output logic        [pqa_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic signed [pqa_pkg::VALUE_WIDTH-1:0]    rsp_out_value
);

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   pqa_pkg::pqa_slot_type mem [QUEUE_DEPTH];
   pqa_pkg::pqa_slot_type rd_data_ff;
   pqa_pkg::pqa_slot_type wr_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic                  wr_en;

   logic [FILL_W-1:0]     fill_ff;
   logic [FILL_W-1:0]     fill_in;
   logic [FILL_W-1:0]     fill_dec;
   logic [ADDR_W-1:0]     cmp_idx_ff;
   logic [ADDR_W-1:0]     cmp_idx_in;
   logic [ADDR_W-1:0]     pos_ff;
   logic [ADDR_W-1:0]     pos_in;
   logic [pqa_pkg::PRIORITY_WIDTH-1:0] best_pri_ff;
   logic [pqa_pkg::PRIORITY_WIDTH-1:0] best_pri_in;
   logic [pqa_pkg::STATUS_WIDTH-1:0]   res_status_ff;
   logic [pqa_pkg::STATUS_WIDTH-1:0]   res_status_in;
   logic [pqa_pkg::VALUE_WIDTH-1:0]    res_value_ff;
   logic [pqa_pkg::VALUE_WIDTH-1:0]    res_value_in;
   logic [pqa_pkg::STATUS_WIDTH-1:0]   rsp_status_ff;
   logic [pqa_pkg::VALUE_WIDTH-1:0]    rsp_value_ff;

   logic                  is_deq;
   logic                  empty;
   logic                  full;
   logic                  take_new;
   logic [ADDR_W-1:0]     last_idx;

   assign is_deq   = (req_opcode == pqa_pkg::OP_DEQ);
   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign fill_dec = fill_ff - FILL_W'(1);
   assign last_idx = fill_dec[ADDR_W-1:0];
   // strict compare keeps the earliest entry among equal priorities
   assign take_new = (cmp_idx_ff == '0) || (rd_data_ff.pri > best_pri_ff);

   assign sts.deq_run    = is_deq && !empty;
   assign sts.scan_last  = (cmp_idx_ff == last_idx);
   assign sts.shift_done = (pos_ff == last_idx);

   always_comb begin
      fill_in       = fill_ff;
      cmp_idx_in    = cmp_idx_ff;
      pos_in        = pos_ff;
      best_pri_in   = best_pri_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = fill_ff[ADDR_W-1:0];
      wr_data.pri   = req_item_priority;
      wr_data.val   = $unsigned(req_item_value);
      priority if (cmd.accept) begin
         res_value_in = '0;
         if (is_deq) begin
            if (empty) begin
               res_status_in = pqa_pkg::ST_EMPTY;
            end else begin
               res_status_in = pqa_pkg::ST_DONE;
               cmp_idx_in    = '0;
            end
         end else if (full) begin
            res_status_in = pqa_pkg::ST_FULL;
         end else begin
            res_status_in = pqa_pkg::ST_DONE;
            wr_en         = 1'b1;
            fill_in       = fill_ff + FILL_W'(1);
         end
      end else if (cmd.scan) begin
         if (take_new) begin
            pos_in       = cmp_idx_ff;
            best_pri_in  = rd_data_ff.pri;
            res_value_in = rd_data_ff.val;
         end
         cmp_idx_in = cmp_idx_ff + ADDR_W'(1);
         // on the last entry, fetch the one after the winner for the shift
         rd_addr    = sts.scan_last ? pos_in + ADDR_W'(1) : cmp_idx_ff + ADDR_W'(1);
      end else if (cmd.shift) begin
         if (sts.shift_done) begin
            fill_in = fill_dec;
         end else begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = rd_data_ff;
            pos_in  = pos_ff + ADDR_W'(1);
            rd_addr = pos_ff + ADDR_W'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff    <= cmp_idx_in;
      pos_ff        <= pos_in;
      best_pri_ff   <= best_pri_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = $signed(rsp_value_ff);

   `PQA_ASSERT_NOW(a_fill_max, fill_ff <= FILL_W'(QUEUE_DEPTH), "fill count above depth")
   `PQA_ASSERT_NEXT(a_fill_dec, cmd.shift && sts.shift_done, fill_ff == FILL_W'($past(fill_ff) - 1), "dequeue did not drop one entry")
   `PQA_ASSERT_IMPL(a_best_order, cmd.scan && (cmp_idx_ff != '0), pos_ff < cmp_idx_ff, "best index ahead of scan")

endmodule

FILE: rtl/priority_queue_array.sv
// Top level of the bounded, stable, max-first priority queue.
// Enqueue and empty/full answers go from accept via the finish state to the output register.
// A dequeue with entries held first scans them for the winner, then shifts later ones down.
// One item is handled at a time; the next is taken in the cycle after the result is loaded.
// The scan and the close-up both run through the one-read one-write slot memory.
// Reset empties the queue (fill count to zero); slot contents stay unset until written.
module priority_queue_array #(
   parameter int QUEUE_DEPTH = pqa_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // request channel
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_opcode,
   input  logic signed [pqa_pkg::VALUE_WIDTH-1:0]    req_item_value,
   input  logic        [pqa_pkg::PRIORITY_WIDTH-1:0] req_item_priority,
   // response channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic        [pqa_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic signed [pqa_pkg::VALUE_WIDTH-1:0]    rsp_out_value
);

   // Command and status buses between the state machine and the datapath.
   pqa_pkg::pqa_cmd_type cmd;
   pqa_pkg::pqa_sts_type sts;

   // Sequence each item: take it in idle; for a dequeue from a non-empty queue,
   // scan for the best entry, close up the gap behind it, then load the output register.
   pqa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold the entries in insertion order, track the running maximum during
   // the scan, shift later entries down one slot, and register the result.
   pqa_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_opcode),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_status        (rsp_status),
      .rsp_out_value     (rsp_out_value)
   );

endmodule
